/* rtl/core/qau_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qau_pkg
// Shared types, op codes and Hamilton product tables for the quaternion unit.
// ----------------------------------------------------------------------------
package qau_pkg;

    localparam int COMP_WIDTH = 32;
    localparam int FRAC_BITS  = 28;

    // product of a component and a widened right operand
    localparam int PROD_W     = 2 * COMP_WIDTH + 1;
    localparam int RND_W      = PROD_W + 1 - FRAC_BITS;
    localparam int SUM_W      = RND_W + 2;

    localparam int SQRT_STEPS = COMP_WIDTH + 1;
    localparam int DIV_STEPS  = FRAC_BITS + 1;
    // squares, sum, root steps, divide prep, divide steps, output
    localparam int NORM_LAT   = SQRT_STEPS + DIV_STEPS + 4;

    localparam logic [2:0] OP_MUL  = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_CONJ = 3'd2;
    localparam logic [2:0] OP_NORM = 3'd3;
    localparam logic [2:0] OP_ROT  = 3'd4;

    typedef logic signed [COMP_WIDTH-1:0] t_comp;
    typedef logic signed [COMP_WIDTH:0]   t_opnd;

    typedef struct packed {
        logic [2:0] op;
        t_comp      a_w;
        t_comp      a_x;
        t_comp      a_y;
        t_comp      a_z;
        t_comp      b_w;
        t_comp      b_x;
        t_comp      b_y;
        t_comp      b_z;
    } t_in;

    typedef struct packed {
        t_comp r_w;
        t_comp r_x;
        t_comp r_y;
        t_comp r_z;
        logic  saturated;
        logic  zero_norm;
    } t_out;

    typedef struct packed {
        t_comp val;
        logic  sat;
    } t_clip;

    // right operand index for each term of each result component
    localparam logic [1:0] HAM_IDX [4][4] = '{
        '{2'd0, 2'd1, 2'd2, 2'd3},
        '{2'd1, 2'd0, 2'd3, 2'd2},
        '{2'd2, 2'd3, 2'd0, 2'd1},
        '{2'd3, 2'd2, 2'd1, 2'd0}
    };

    // bit j set: term j is subtracted
    localparam logic [3:0] HAM_NEG [4] = '{4'b1110, 4'b1000, 4'b0010, 4'b0100};

    function automatic t_clip clip_comp(input logic signed [SUM_W-1:0] v);
        t_clip                          c;
        logic [SUM_W-COMP_WIDTH:0]      top;
        top = v[SUM_W-1:COMP_WIDTH-1];
        if (top == '0 || top == '1) begin
            c.val = v[COMP_WIDTH-1:0];
            c.sat = 1'b0;
        end else begin
            c.sat = 1'b1;
            c.val = v[SUM_W-1] ? {1'b1, {(COMP_WIDTH-1){1'b0}}}
                               : {1'b0, {(COMP_WIDTH-1){1'b1}}};
        end
        return c;
    endfunction

endpackage

/* rtl/core/qau_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qau_lane
// One component of a Hamilton product: four products, rounding, signed sum
// and saturation over two register stages.
// ----------------------------------------------------------------------------
module qau_lane (
    input  logic           i_clk,
    input  qau_pkg::t_comp i_l [4],
    input  qau_pkg::t_opnd i_r [4],
    input  logic [3:0]     i_neg,
    output qau_pkg::t_comp o_comp,
    output logic           o_sat
);
    import qau_pkg::*;

    localparam logic signed [PROD_W:0] HALF = (PROD_W + 1)'(1) << (FRAC_BITS - 1);

    logic signed [PROD_W-1:0] ext_l  [4];
    logic signed [PROD_W-1:0] ext_r  [4];
    logic signed [PROD_W-1:0] r_prod [4];
    logic [3:0]               r_neg;
    logic signed [PROD_W:0]   biased [4];
    logic signed [RND_W-1:0]  rnd    [4];
    logic signed [SUM_W-1:0]  acc;
    t_clip                    clipped;
    t_comp                    r_comp;
    logic                     r_sat;

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            ext_l[j] = PROD_W'(i_l[j]);
            ext_r[j] = PROD_W'(i_r[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 4; j++) begin
            r_prod[j] <= ext_l[j] * ext_r[j];
        end
        r_neg <= i_neg;
    end

    // round half up per product, then sum exactly
    always_comb begin
        acc = '0;
        for (int j = 0; j < 4; j++) begin
            biased[j] = $signed({r_prod[j][PROD_W-1], r_prod[j]}) + HALF;
            rnd[j]    = RND_W'(biased[j] >>> FRAC_BITS);
            if (r_neg[j]) begin
                acc = acc - SUM_W'(rnd[j]);
            end else begin
                acc = acc + SUM_W'(rnd[j]);
            end
        end
        clipped = clip_comp(acc);
    end

    always_ff @(posedge i_clk) begin
        r_comp <= clipped.val;
        r_sat  <= clipped.sat;
    end

    assign o_comp = r_comp;
    assign o_sat  = r_sat;

endmodule

/* rtl/core/qau_norm.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qau_norm
// Pipelined unit normalization: sum of squares, one root bit per stage,
// then four divider lanes with one quotient bit per stage.
// ----------------------------------------------------------------------------
module qau_norm (
    input  logic           i_clk,
    input  qau_pkg::t_comp i_a [4],
    output qau_pkg::t_comp o_q [4],
    output logic           o_zero
);
    import qau_pkg::*;

    localparam int SQ_W   = 2 * COMP_WIDTH;
    localparam int RAD_W  = 2 * SQRT_STEPS;
    localparam int ROOT_W = SQRT_STEPS;
    localparam int REM_W  = COMP_WIDTH + 4;
    localparam int NUM_W  = COMP_WIDTH + FRAC_BITS + 1;
    localparam int Q_W    = DIV_STEPS;
    localparam logic [RAD_W-1:0] S_MAX = RAD_W'(64'hFFFF_FFFF_FFFF_FFFF);

    logic signed [SQ_W-1:0]  ext_a [4];
    logic [SQ_W-1:0]         r_sq  [4];
    logic [COMP_WIDTH-1:0]   r_mag [SQRT_STEPS+2][4];
    logic [3:0]              r_neg [SQRT_STEPS+2];
    logic [RAD_W-1:0]        sum_sq;

    logic [RAD_W-1:0]        r_rad  [SQRT_STEPS+1];
    logic [REM_W-1:0]        r_rem  [SQRT_STEPS+1];
    logic [ROOT_W-1:0]       r_root [SQRT_STEPS+1];
    logic [RAD_W-1:0]        n_rad  [SQRT_STEPS];
    logic [REM_W-1:0]        n_rem  [SQRT_STEPS];
    logic [ROOT_W-1:0]       n_root [SQRT_STEPS];
    logic [REM_W-1:0]        rem2   [SQRT_STEPS];
    logic [REM_W-1:0]        trial  [SQRT_STEPS];

    logic [NUM_W-1:0]        r_drem  [DIV_STEPS+1][4];
    logic [Q_W-1:0]          r_q     [DIV_STEPS+1][4];
    logic [ROOT_W-1:0]       r_dm    [DIV_STEPS+1];
    logic [3:0]              r_dneg  [DIV_STEPS+1];
    logic                    r_dzero [DIV_STEPS+1];
    logic [NUM_W-1:0]        n_drem  [DIV_STEPS][4];
    logic [Q_W-1:0]          n_q     [DIV_STEPS][4];
    logic [NUM_W-1:0]        dsr     [DIV_STEPS];

    t_comp                   r_out [4];
    logic                    r_zero;
    t_comp                   qx    [4];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            ext_a[i] = SQ_W'(i_a[i]);
        end
    end

    // squares and magnitudes
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            r_sq[i]     <= ext_a[i] * ext_a[i];
            r_mag[0][i] <= i_a[i][COMP_WIDTH-1] ? (~i_a[i] + 1'b1) : i_a[i];
            r_neg[0][i] <= i_a[i][COMP_WIDTH-1];
        end
        for (int k = 1; k < SQRT_STEPS + 2; k++) begin
            r_mag[k] <= r_mag[k-1];
            r_neg[k] <= r_neg[k-1];
        end
    end

    assign sum_sq = RAD_W'(r_sq[0]) + RAD_W'(r_sq[1]) + RAD_W'(r_sq[2]) + RAD_W'(r_sq[3]);

    // restoring square root, two radicand bits per stage
    always_comb begin
        for (int k = 0; k < SQRT_STEPS; k++) begin
            rem2[k]  = {r_rem[k][REM_W-3:0], r_rad[k][RAD_W-1:RAD_W-2]};
            trial[k] = REM_W'({r_root[k], 2'b01});
            n_rad[k] = {r_rad[k][RAD_W-3:0], 2'b00};
            if (rem2[k] >= trial[k]) begin
                n_rem[k]  = rem2[k] - trial[k];
                n_root[k] = {r_root[k][ROOT_W-2:0], 1'b1};
            end else begin
                n_rem[k]  = rem2[k];
                n_root[k] = {r_root[k][ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rad[0]  <= (sum_sq > S_MAX) ? S_MAX : sum_sq;
        r_rem[0]  <= '0;
        r_root[0] <= '0;
        for (int k = 1; k <= SQRT_STEPS; k++) begin
            r_rad[k]  <= n_rad[k-1];
            r_rem[k]  <= n_rem[k-1];
            r_root[k] <= n_root[k-1];
        end
    end

    // divider: quotient is at most 2^FRAC_BITS since the root bounds each magnitude
    always_comb begin
        for (int j = 0; j < DIV_STEPS; j++) begin
            dsr[j] = NUM_W'(r_dm[j]) << (DIV_STEPS - 1 - j);
            for (int i = 0; i < 4; i++) begin
                if (r_drem[j][i] >= dsr[j]) begin
                    n_drem[j][i] = r_drem[j][i] - dsr[j];
                    n_q[j][i]    = {r_q[j][i][Q_W-2:0], 1'b1};
                end else begin
                    n_drem[j][i] = r_drem[j][i];
                    n_q[j][i]    = {r_q[j][i][Q_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dm[0]    <= r_root[SQRT_STEPS];
        r_dneg[0]  <= r_neg[SQRT_STEPS+1];
        r_dzero[0] <= (r_root[SQRT_STEPS] == '0);
        for (int i = 0; i < 4; i++) begin
            r_drem[0][i] <= (NUM_W'(r_mag[SQRT_STEPS+1][i]) << FRAC_BITS)
                          + NUM_W'(r_root[SQRT_STEPS] >> 1);
            r_q[0][i]    <= '0;
        end
        for (int j = 1; j <= DIV_STEPS; j++) begin
            r_dm[j]    <= r_dm[j-1];
            r_dneg[j]  <= r_dneg[j-1];
            r_dzero[j] <= r_dzero[j-1];
            r_drem[j]  <= n_drem[j-1];
            r_q[j]     <= n_q[j-1];
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            qx[i] = COMP_WIDTH'(r_q[DIV_STEPS][i]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            if (r_dzero[DIV_STEPS]) begin
                r_out[i] <= '0;
            end else begin
                r_out[i] <= r_dneg[DIV_STEPS][i] ? -qx[i] : qx[i];
            end
        end
        r_zero <= r_dzero[DIV_STEPS];
    end

    assign o_q    = r_out;
    assign o_zero = r_zero;

endmodule

/* rtl/core/quaternion_arithmetic_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_arithmetic_unit
// Q3.28 quaternion multiply, add, conjugate, normalize and vector rotate.
//
// Channel   Direction  Handshake             Payload
// request   in         start, busy           i_item   (t_in)
// result    out        o_strobe (1 cycle)    o_result (t_out)
//
// One transaction is accepted every cycle; busy is always low.
// Every op has the same latency from accept to strobe, set by the normalize
// pipeline: 33 root stages and 29 divider stages.
// Multiply and rotate run in four Hamilton product lanes (rotate makes two
// passes); shorter paths are delayed to line up with normalize.
// Synchronous reset clears the valid pipeline; data in flight is dropped.
// The receiver cannot stall; each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module quaternion_arithmetic_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  qau_pkg::t_in  i_item,
    output logic          o_strobe,
    output qau_pkg::t_out o_result
);
    import qau_pkg::*;

    localparam int FAST_LEN = NORM_LAT - 4;

    t_comp  in_a   [4];
    t_comp  in_b   [4];
    t_opnd  in_b1  [4];
    t_opnd  lane_r1 [4][4];
    t_opnd  conj_a [4];
    t_opnd  lane_r2 [4][4];
    t_comp  t1     [4];
    t_comp  t2     [4];
    logic   [3:0] s1;
    logic   [3:0] s2;

    t_comp  ac     [4];
    logic   ac_sat;
    t_clip  c_tmp  [4];

    logic   r_vld  [NORM_LAT];
    logic   [2:0] r_op [NORM_LAT];
    t_comp  r_a0   [4];
    t_comp  r_a1   [4];
    t_comp  r_ac   [4][4];
    logic   [3:0] r_acsat;
    t_comp  r_mul2 [4];
    t_comp  r_mul3 [4];
    logic   [3:0] r_s1_2;
    logic   [3:0] r_s1_3;

    t_out   n_fast;
    t_out   r_fast [FAST_LEN];
    t_comp  nq     [4];
    logic   nzero;
    t_out   r_result;
    logic   r_strobe;

    assign busy = 1'b0;

    assign in_a = '{i_item.a_w, i_item.a_x, i_item.a_y, i_item.a_z};
    assign in_b = '{i_item.b_w, i_item.b_x, i_item.b_y, i_item.b_z};

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            in_b1[j] = (COMP_WIDTH + 1)'(in_b[j]);
        end
        // rotate uses the pure vector (0, v)
        if (i_item.op == OP_ROT) begin
            in_b1[0] = '0;
        end
        conj_a[0] = (COMP_WIDTH + 1)'(r_a1[0]);
        for (int j = 1; j < 4; j++) begin
            conj_a[j] = -((COMP_WIDTH + 1)'(r_a1[j]));
        end
        for (int k = 0; k < 4; k++) begin
            for (int j = 0; j < 4; j++) begin
                lane_r1[k][j] = in_b1[HAM_IDX[k][j]];
                lane_r2[k][j] = conj_a[HAM_IDX[k][j]];
            end
        end
    end

    for (genvar k = 0; k < 4; k++) begin : g_lane
        qau_lane u_pass1 (
            .i_clk  (i_clk),
            .i_l    (in_a),
            .i_r    (lane_r1[k]),
            .i_neg  (HAM_NEG[k]),
            .o_comp (t1[k]),
            .o_sat  (s1[k])
        );
        qau_lane u_pass2 (
            .i_clk  (i_clk),
            .i_l    (t1),
            .i_r    (lane_r2[k]),
            .i_neg  (HAM_NEG[k]),
            .o_comp (t2[k]),
            .o_sat  (s2[k])
        );
    end

    qau_norm u_norm (
        .i_clk  (i_clk),
        .i_a    (in_a),
        .o_q    (nq),
        .o_zero (nzero)
    );

    // add and conjugate
    always_comb begin
        ac_sat = 1'b0;
        for (int j = 0; j < 4; j++) begin
            if (i_item.op == OP_ADD) begin
                c_tmp[j] = clip_comp(SUM_W'(in_a[j]) + SUM_W'(in_b[j]));
            end else begin
                c_tmp[j] = clip_comp(-SUM_W'(in_a[j]));
            end
        end
        for (int j = 0; j < 4; j++) begin
            ac[j] = c_tmp[j].val;
        end
        ac_sat = c_tmp[1].sat | c_tmp[2].sat | c_tmp[3].sat;
        if (i_item.op == OP_ADD) begin
            ac_sat = ac_sat | c_tmp[0].sat;
        end else begin
            ac[0] = in_a[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NORM_LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_strobe <= 1'b0;
        end else begin
            r_vld[0] <= start && !busy;
            for (int k = 1; k < NORM_LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
            r_strobe <= r_vld[NORM_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_op[0] <= i_item.op;
        for (int k = 1; k < NORM_LAT; k++) begin
            r_op[k] <= r_op[k-1];
        end
        r_a0       <= in_a;
        r_a1       <= r_a0;
        r_ac[0]    <= ac;
        r_acsat[0] <= ac_sat;
        for (int k = 1; k < 4; k++) begin
            r_ac[k]    <= r_ac[k-1];
            r_acsat[k] <= r_acsat[k-1];
        end
        r_mul2 <= t1;
        r_mul3 <= r_mul2;
        r_s1_2 <= s1;
        r_s1_3 <= r_s1_2;
    end

    // merge of the fast paths
    always_comb begin
        n_fast = '0;
        case (r_op[3]) inside
            OP_MUL: begin
                n_fast.r_w       = r_mul3[0];
                n_fast.r_x       = r_mul3[1];
                n_fast.r_y       = r_mul3[2];
                n_fast.r_z       = r_mul3[3];
                n_fast.saturated = |r_s1_3;
            end
            OP_ADD, OP_CONJ: begin
                n_fast.r_w       = r_ac[3][0];
                n_fast.r_x       = r_ac[3][1];
                n_fast.r_y       = r_ac[3][2];
                n_fast.r_z       = r_ac[3][3];
                n_fast.saturated = r_acsat[3];
            end
            OP_ROT: begin
                n_fast.r_x       = t2[1];
                n_fast.r_y       = t2[2];
                n_fast.r_z       = t2[3];
                n_fast.saturated = (|r_s1_3) | s2[1] | s2[2] | s2[3];
            end
            default: begin
                n_fast = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_fast[0] <= n_fast;
        for (int k = 1; k < FAST_LEN; k++) begin
            r_fast[k] <= r_fast[k-1];
        end
        if (r_op[NORM_LAT-1] == OP_NORM) begin
            r_result.r_w       <= nq[0];
            r_result.r_x       <= nq[1];
            r_result.r_y       <= nq[2];
            r_result.r_z       <= nq[3];
            r_result.saturated <= 1'b0;
            r_result.zero_norm <= nzero;
        end else begin
            r_result <= r_fast[FAST_LEN-1];
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start, NORM_LAT + 1))
        else $error("result strobe without a matching accepted transaction");

    a_zero_op : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.zero_norm) |-> ($past(i_item.op, NORM_LAT + 1) == OP_NORM))
        else $error("zero_norm raised for an op other than normalize");

    a_zero_val : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.zero_norm) |->
            (o_result.r_w == '0 && o_result.r_x == '0 && o_result.r_y == '0 &&
             o_result.r_z == '0 && !o_result.saturated))
        else $error("zero_norm result carries nonzero data");

    a_rot_w : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && $past(i_item.op, NORM_LAT + 1) == OP_ROT) |-> (o_result.r_w == '0))
        else $error("rotate result has nonzero scalar part");

endmodule

/* verif/quaternion_arithmetic_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_arithmetic_unit_tb
// Drives directed corner cases and random quaternion operations into the
// unit with random start gaps, predicts each result with a local fixed-point
// model and compares every strobed result against the oldest prediction.
// ----------------------------------------------------------------------------
module quaternion_arithmetic_unit_tb;
    import qau_pkg::*;

    localparam logic [2:0] OP_LAST     = 3'd7;
    localparam int         IDLE_LIMIT  = 2000;
    localparam int         SETTLE_CYC  = 2 * (NORM_LAT + 1);
    localparam int         N_RANDOM    = 530;
    localparam longint     CMAX        = (64'sd1 <<< (COMP_WIDTH - 1)) - 1;
    localparam longint     CMIN        = -CMAX - 1;

    logic  i_clk = 1'b0;
    logic  i_rst_n;
    logic  start = 1'b0;
    logic  busy;
    t_in   i_item = '0;
    logic  o_strobe;
    t_out  o_result;

    t_in   pending_ops[$];
    t_out  expected_results[$];
    int    drain_points[$];
    int    sent_cnt = 0;
    int    gap_left = 0;
    bit    burst_mode = 1'b0;
    int    idle_cycles = 0;
    bit    failed = 1'b0;

    quaternion_arithmetic_unit uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ---------------- prediction ----------------
    function automatic longint round_mul(input longint x, input longint y);
        return (x * y + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    endfunction

    function automatic longint saturate(input longint v, inout bit sat);
        if (v > CMAX) begin
            sat = 1'b1;
            return CMAX;
        end
        if (v < CMIN) begin
            sat = 1'b1;
            return CMIN;
        end
        return v;
    endfunction

    function automatic void hamilton(input longint l[4], input longint r[4],
                                     output longint o[4]);
        o[0] = round_mul(l[0], r[0]) - round_mul(l[1], r[1])
             - round_mul(l[2], r[2]) - round_mul(l[3], r[3]);
        o[1] = round_mul(l[0], r[1]) + round_mul(l[1], r[0])
             + round_mul(l[2], r[3]) - round_mul(l[3], r[2]);
        o[2] = round_mul(l[0], r[2]) - round_mul(l[1], r[3])
             + round_mul(l[2], r[0]) + round_mul(l[3], r[1]);
        o[3] = round_mul(l[0], r[3]) + round_mul(l[1], r[2])
             - round_mul(l[2], r[1]) + round_mul(l[3], r[0]);
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = '0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic t_out quat_result(input t_in it);
        longint      a[4], b[4], r[4], t[4], c[4];
        bit          sat, zn;
        logic [64:0] sq_sum;
        logic [63:0] root, mag, quo;
        t_out        res;
        sat = 0;
        zn  = 0;
        a = '{longint'(it.a_w), longint'(it.a_x), longint'(it.a_y), longint'(it.a_z)};
        b = '{longint'(it.b_w), longint'(it.b_x), longint'(it.b_y), longint'(it.b_z)};
        r = '{0, 0, 0, 0};
        case (it.op)
            OP_MUL: begin
                hamilton(a, b, t);
                for (int i = 0; i < 4; i++) r[i] = saturate(t[i], sat);
            end
            OP_ADD: begin
                for (int i = 0; i < 4; i++) r[i] = saturate(a[i] + b[i], sat);
            end
            OP_CONJ: begin
                r[0] = a[0];
                for (int i = 1; i < 4; i++) r[i] = saturate(-a[i], sat);
            end
            OP_NORM: begin
                sq_sum = '0;
                for (int i = 0; i < 4; i++) sq_sum = sq_sum + 65'(a[i] * a[i]);
                if (sq_sum[64]) sq_sum = {1'b0, {64{1'b1}}};
                root = int_sqrt(sq_sum[63:0]);
                if (root == 0) begin
                    zn = 1;
                end else begin
                    for (int i = 0; i < 4; i++) begin
                        mag  = 64'(a[i] < 0 ? -a[i] : a[i]) << FRAC_BITS;
                        quo  = (mag + root / 2) / root;
                        r[i] = saturate(a[i] < 0 ? -longint'(quo) : longint'(quo), sat);
                    end
                end
            end
            OP_ROT: begin
                b[0] = 0;
                hamilton(a, b, t);
                for (int i = 0; i < 4; i++) t[i] = saturate(t[i], sat);
                c[0] = a[0];
                for (int i = 1; i < 4; i++) c[i] = -a[i];
                hamilton(t, c, r);
                r[0] = 0;
                for (int i = 1; i < 4; i++) r[i] = saturate(r[i], sat);
            end
            default: ;
        endcase
        res.r_w       = t_comp'(r[0]);
        res.r_x       = t_comp'(r[1]);
        res.r_y       = t_comp'(r[2]);
        res.r_z       = t_comp'(r[3]);
        res.saturated = sat;
        res.zero_norm = zn;
        return res;
    endfunction

    // ---------------- stimulus helpers ----------------
    function automatic t_comp rand_comp();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4) return t_comp'($urandom);
        if (sel < 8) return t_comp'($urandom_range(0, 1 << 29)) - (t_comp'(1) <<< FRAC_BITS);
        if (sel == 8) return $urandom_range(0, 1) ? t_comp'(CMAX) : t_comp'(CMIN);
        return t_comp'($urandom_range(0, 8)) - 4;
    endfunction

    function automatic t_in make_op(input logic [2:0] op, input t_comp aw, input t_comp ax,
                                    input t_comp ay, input t_comp az, input t_comp bw,
                                    input t_comp bx, input t_comp by, input t_comp bz);
        t_in it;
        it = '{op, aw, ax, ay, az, bw, bx, by, bz};
        return it;
    endfunction

    // ---------------- driver ----------------
    always @(posedge i_clk) begin
        t_in nxt_item;
        bit  nxt_start;
        nxt_item  = i_item;
        nxt_start = 1'b0;
        if (!i_rst_n) begin
            gap_left <= 0;
        end else begin
            if (start && !busy) begin
                expected_results.push_back(quat_result(i_item));
                sent_cnt++;
            end
            if (start && busy) begin
                nxt_start = 1'b1;
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
            end else if (pending_ops.size() > 0 &&
                         !(drain_points.size() > 0 && drain_points[0] == sent_cnt &&
                           expected_results.size() > 0)) begin
                if (drain_points.size() > 0 && drain_points[0] == sent_cnt)
                    void'(drain_points.pop_front());
                nxt_item  = pending_ops.pop_front();
                nxt_start = 1'b1;
                if ($urandom_range(0, 49) == 0) burst_mode = !burst_mode;
                if (burst_mode) gap_left <= 0;
                else if ($urandom_range(0, 19) == 0) gap_left <= $urandom_range(10, 40);
                else if ($urandom_range(0, 2) == 0) gap_left <= $urandom_range(1, 3);
                else gap_left <= 0;
            end
        end
        start  <= nxt_start;
        i_item <= nxt_item;
    end

    // ---------------- monitor ----------------
    always @(posedge i_clk) begin
        t_out exp_r;
        if (i_rst_n && o_strobe) begin
            if (expected_results.size() == 0) begin
                $error("result with no transaction outstanding");
                failed = 1;
            end else begin
                exp_r = expected_results.pop_front();
                if (o_result.r_w !== exp_r.r_w) begin
                    $error("r_w expected %0d actual %0d", exp_r.r_w, o_result.r_w);
                    failed = 1;
                end
                if (o_result.r_x !== exp_r.r_x) begin
                    $error("r_x expected %0d actual %0d", exp_r.r_x, o_result.r_x);
                    failed = 1;
                end
                if (o_result.r_y !== exp_r.r_y) begin
                    $error("r_y expected %0d actual %0d", exp_r.r_y, o_result.r_y);
                    failed = 1;
                end
                if (o_result.r_z !== exp_r.r_z) begin
                    $error("r_z expected %0d actual %0d", exp_r.r_z, o_result.r_z);
                    failed = 1;
                end
                if (o_result.saturated !== exp_r.saturated) begin
                    $error("saturated expected %0b actual %0b", exp_r.saturated,
                           o_result.saturated);
                    failed = 1;
                end
                if (o_result.zero_norm !== exp_r.zero_norm) begin
                    $error("zero_norm expected %0b actual %0b", exp_r.zero_norm,
                           o_result.zero_norm);
                    failed = 1;
                end
            end
        end
    end

    // watchdog: cycles with neither an accepted transaction nor a result
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------- sequence ----------------
    initial begin
        t_comp one, mx, mn;
        logic [2:0] op;
        i_rst_n    = 1'b0;
        one = t_comp'(1) <<< FRAC_BITS;
        mx  = t_comp'(CMAX);
        mn  = t_comp'(CMIN);

        // directed corners
        pending_ops.push_back(make_op(OP_MUL, mx, mx, mx, mx, mx, mx, mx, mx));
        pending_ops.push_back(make_op(OP_MUL, mn, mn, mn, mn, mn, mn, mn, mn));
        pending_ops.push_back(make_op(OP_MUL, one, 0, 0, 0, 5, -7, 9, -11));
        pending_ops.push_back(make_op(OP_MUL, mx, mn, mx, mn, mn, mx, mn, mx));
        pending_ops.push_back(make_op(OP_ADD, mx, mn, mx, mn, mx, mn, 1, -1));
        pending_ops.push_back(make_op(OP_ADD, 0, -1, 1, 0, 0, 1, -1, 0));
        pending_ops.push_back(make_op(OP_CONJ, mn, mn, mn, mn, 0, 0, 0, 0));
        pending_ops.push_back(make_op(OP_CONJ, mx, mx, -1, 0, mx, mn, 3, 4));
        pending_ops.push_back(make_op(OP_NORM, 0, 0, 0, 0, mx, mx, mx, mx));
        pending_ops.push_back(make_op(OP_NORM, mn, mn, mn, mn, 0, 0, 0, 0));
        pending_ops.push_back(make_op(OP_NORM, mx, mx, mx, mx, 0, 0, 0, 0));
        pending_ops.push_back(make_op(OP_NORM, 0, 0, 0, 1, 0, 0, 0, 0));
        pending_ops.push_back(make_op(OP_NORM, -1, 1, -1, 1, 0, 0, 0, 0));
        pending_ops.push_back(make_op(OP_NORM, 3 * one, -4 * one, 0, 0, 0, 0, 0, 0));
        pending_ops.push_back(make_op(OP_ROT, one, 0, 0, 0, mx, one, -one, 3));
        pending_ops.push_back(make_op(OP_ROT, mx, mx, mx, mx, mn, mx, mx, mx));
        pending_ops.push_back(make_op(OP_ROT, mn, mn, mn, mn, 0, mn, mn, mn));
        pending_ops.push_back(make_op(OP_ROT, 0, one, 0, 0, 0, 0, one, 0));
        for (op = OP_ROT + 3'd1; op <= OP_LAST && op != 0; op++)
            pending_ops.push_back(make_op(op, mx, mn, -1, 1, mn, mx, 1, -1));

        // hold the sender until the directed part has fully drained, and once more later
        drain_points.push_back(pending_ops.size());
        drain_points.push_back(pending_ops.size() + 300);

        for (int n = 0; n < N_RANDOM; n++) begin
            op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(OP_ROT + 1, OP_LAST))
                                              : 3'($urandom_range(OP_MUL, OP_ROT));
            pending_ops.push_back(make_op(op, rand_comp(), rand_comp(), rand_comp(),
                                          rand_comp(), rand_comp(), rand_comp(),
                                          rand_comp(), rand_comp()));
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_ops.size() == 0);
        @(posedge i_clk);
        while (start || expected_results.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);

        if (!failed && expected_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/core/qau_pkg.sv
rtl/core/qau_lane.sv
rtl/core/qau_norm.sv
rtl/core/quaternion_arithmetic_unit.sv
verif/quaternion_arithmetic_unit_tb.sv
